// ===== rtl/och_pkg.sv =====
// Shared types and constants for the chained cone hash table.
package och_pkg;

  localparam int HEAD_BITS_DEF = 9;
  localparam int CAPACITY_DEF  = 256;
  localparam int QUEUE_DEPTH   = 4;

  localparam int KEY_IN_W = 24;
  localparam int CONE_W   = 20;
  localparam int KEY_W    = 2 * KEY_IN_W + 1;
  localparam int STATUS_W = 3;

  localparam logic [31:0] MUL_ANGLE  = 32'd11408669;
  localparam logic [31:0] MUL_RADIUS = 32'd97416181;
  localparam logic [31:0] MUL_SIGN   = 32'd71053447;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_REJECTED = 3'd4
  } och_status_t;

  typedef struct packed {
    logic                       kind;
    logic signed [KEY_IN_W-1:0] angle_key;
    logic signed [KEY_IN_W-1:0] radius_key;
    logic                       positive_sign;
    logic [CONE_W-1:0]          cone_id;
  } och_item_t;

endpackage

// ===== rtl/och_front.sv =====
// Front end: accepts requests and computes the bucket index in two stages.
module och_front import och_pkg::*; #(
  parameter int HEAD_BITS = HEAD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  och_item_t                              in_item,
  input  logic                                   back_ready,
  output logic                                   q_push,
  output logic [$bits(och_item_t)+HEAD_BITS-1:0] q_data,
  input  logic                                   q_full
);

  localparam logic [HEAD_BITS-1:0] MA = MUL_ANGLE[HEAD_BITS-1:0];
  localparam logic [HEAD_BITS-1:0] MR = MUL_RADIUS[HEAD_BITS-1:0];
  localparam logic [HEAD_BITS-1:0] MS = MUL_SIGN[HEAD_BITS-1:0];

  logic                 s1_v_r, s1_v_nxt;
  och_item_t            s1_item_r;
  logic [HEAD_BITS-1:0] s1_pa_r, s1_pr_r;
  logic                 s2_v_r, s2_v_nxt;
  och_item_t            s2_item_r;
  logic [HEAD_BITS-1:0] s2_bucket_r, s2_bucket_nxt;
  logic [HEAD_BITS-1:0] pa_nxt, pr_nxt, ps;
  logic                 s1_adv, s2_adv, accept;

  // only the low bucket bits of the 32-bit hash survive the mask
  assign pa_nxt = in_item.angle_key[HEAD_BITS-1:0] * MA;
  assign pr_nxt = in_item.radius_key[HEAD_BITS-1:0] * MR;
  assign ps     = s1_item_r.positive_sign ? MS : '0;
  assign s2_bucket_nxt = s1_pa_r + s1_pr_r + ps;

  assign q_push = s2_v_r & ~q_full;
  assign q_data = {s2_item_r, s2_bucket_r};
  assign s2_adv = ~s2_v_r | ~q_full;
  assign s1_adv = ~s1_v_r | s2_adv;
  assign in_stall = ~s1_adv | ~back_ready;
  assign accept = in_valid & ~in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    if (s2_adv) begin
      s2_v_nxt = s1_v_r;
    end
    if (s1_adv) begin
      s1_v_nxt = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
      s1_pa_r   <= pa_nxt;
      s1_pr_r   <= pr_nxt;
    end
    if (s2_adv && s1_v_r) begin
      s2_item_r   <= s1_item_r;
      s2_bucket_r <= s2_bucket_nxt;
    end
  end

endmodule

// ===== rtl/och_fifo.sv =====
// Small request queue between the front end and the chain walker.
module och_fifo import och_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/och_back.sv =====
// Back end: head table, entry store, chain walk and result register.
module och_back import och_pkg::*; #(
  parameter int HEAD_BITS = HEAD_BITS_DEF,
  parameter int CAPACITY  = CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  output logic                                   back_ready,
  input  logic                                   q_valid,
  input  logic [$bits(och_item_t)+HEAD_BITS-1:0] q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [STATUS_W-1:0]                    out_status,
  output logic [CONE_W-1:0]                      out_found_cone
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W = IDX_W + 1;
  localparam int HEADS  = 1 << HEAD_BITS;
  localparam int QW     = $bits(och_item_t) + HEAD_BITS;
  localparam logic [LINK_W-1:0] NIL = '1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_HEAD   = 5'b00100,
    S_ENTRY  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  logic [LINK_W-1:0] heads [HEADS];
  logic [KEY_W-1:0]  ent_keys [CAPACITY];
  logic [CONE_W-1:0] ent_cone [CAPACITY];
  logic [LINK_W-1:0] ent_link [CAPACITY];

  state_t               state_r, state_nxt;
  logic [HEAD_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [LINK_W-1:0]    count_r, count_nxt;
  och_item_t            cur_item_r;
  logic [HEAD_BITS-1:0] cur_bucket_r;
  logic [IDX_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [CONE_W-1:0]    hit_cone_r, hit_cone_nxt;
  logic [LINK_W-1:0]    head_q_r;
  logic [KEY_W-1:0]     ek_q_r;
  logic [CONE_W-1:0]    ec_q_r;
  logic [LINK_W-1:0]    el_q_r;
  logic                 out_valid_r, out_valid_nxt;
  och_status_t          out_status_r, out_status_nxt;
  logic [CONE_W-1:0]    out_cone_r, out_cone_nxt;

  och_item_t            q_item;
  logic [HEAD_BITS-1:0] q_bucket;
  logic [KEY_W-1:0]     cur_key;
  logic                 head_we, head_re, ent_re, new_we, cone_we, out_load;
  logic [HEAD_BITS-1:0] head_waddr;
  logic [LINK_W-1:0]    head_wdata;
  logic [IDX_W-1:0]     ent_raddr, cone_waddr;

  assign q_item   = och_item_t'(q_data[QW-1:HEAD_BITS]);
  assign q_bucket = q_data[HEAD_BITS-1:0];
  assign cur_key  = {cur_item_r.positive_sign, cur_item_r.radius_key, cur_item_r.angle_key};

  assign back_ready     = (state_r != S_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_cone = out_cone_r;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    count_nxt      = count_r;
    cur_idx_nxt    = cur_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cone_nxt   = hit_cone_r;
    out_status_nxt = out_status_r;
    out_cone_nxt   = out_cone_r;
    q_pop          = 1'b0;
    head_we        = 1'b0;
    head_re        = 1'b0;
    head_waddr     = clr_addr_r;
    head_wdata     = NIL;
    ent_re         = 1'b0;
    ent_raddr      = head_q_r[IDX_W-1:0];
    new_we         = 1'b0;
    cone_we        = 1'b0;
    cone_waddr     = hit_idx_r;
    out_load       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        head_we      = 1'b1;
        clr_addr_nxt = clr_addr_r + HEAD_BITS'(1);
        if (clr_addr_r == HEAD_BITS'(HEADS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          head_re   = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (head_q_r < count_r) begin
          ent_re      = 1'b1;
          ent_raddr   = head_q_r[IDX_W-1:0];
          cur_idx_nxt = head_q_r[IDX_W-1:0];
          state_nxt   = S_ENTRY;
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_RESULT;
        end
      end
      S_ENTRY: begin
        if (ek_q_r == cur_key) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = cur_idx_r;
          hit_cone_nxt = ec_q_r;
          state_nxt    = S_RESULT;
        end else if (el_q_r < count_r) begin
          ent_re      = 1'b1;
          ent_raddr   = el_q_r[IDX_W-1:0];
          cur_idx_nxt = el_q_r[IDX_W-1:0];
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load     = 1'b1;
          out_cone_nxt = '0;
          state_nxt    = S_IDLE;
          if (cur_item_r.kind == KIND_LOOKUP) begin
            if (found_r) begin
              out_status_nxt = ST_HIT;
              out_cone_nxt   = hit_cone_r;
            end else begin
              out_status_nxt = ST_MISS;
            end
          end else if (found_r) begin
            cone_we        = 1'b1;
            cone_waddr     = hit_idx_r;
            out_status_nxt = ST_UPDATED;
          end else if (count_r == LINK_W'(CAPACITY)) begin
            out_status_nxt = ST_REJECTED;
          end else begin
            // append at the end of the store and make it the chain head
            new_we         = 1'b1;
            cone_we        = 1'b1;
            cone_waddr     = count_r[IDX_W-1:0];
            head_we        = 1'b1;
            head_waddr     = cur_bucket_r;
            head_wdata     = count_r;
            count_nxt      = count_r + LINK_W'(1);
            out_status_nxt = ST_INSERTED;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r & out_stall) | out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r    <= cur_idx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_cone_r   <= hit_cone_nxt;
    out_status_r <= out_status_nxt;
    out_cone_r   <= out_cone_nxt;
    if (q_pop) begin
      cur_item_r   <= q_item;
      cur_bucket_r <= q_bucket;
    end
  end

  // head table
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_q_r <= heads[q_bucket];
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (new_we) begin
      ent_keys[count_r[IDX_W-1:0]] <= cur_key;
      ent_link[count_r[IDX_W-1:0]] <= head_q_r;
    end
    if (cone_we) begin
      ent_cone[cone_waddr] <= cur_item_r.cone_id;
    end
    if (ent_re) begin
      ek_q_r <= ent_keys[ent_raddr];
      ec_q_r <= ent_cone[ent_raddr];
      el_q_r <= ent_link[ent_raddr];
    end
  end

endmodule

// ===== rtl/oblique_cone_hash_table_top.sv =====
// Path: front stage registers, the queue, then in the walker the head table read, an entry store
// read per entry visited, and the result register. The walker pops a request only when done with
// the last one's chain walk and its result. The front end and a 4-deep queue keep taking requests
// while the walker is busy. Reset (rst_n low, synchronous) empties the store; the head table is then
// cleared one bucket a cycle, with in_stall held high throughout.
module oblique_cone_hash_table_top import och_pkg::*; #(
  parameter int HEAD_BITS = HEAD_BITS_DEF,
  parameter int CAPACITY  = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic signed [KEY_IN_W-1:0] in_angle_key,
  input  logic signed [KEY_IN_W-1:0] in_radius_key,
  input  logic                       in_positive_sign,
  input  logic [CONE_W-1:0]          in_cone_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [CONE_W-1:0]          out_found_cone
);

  localparam int QW = $bits(och_item_t) + HEAD_BITS;

  och_item_t      in_item;
  logic           back_ready;
  logic           q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]  q_wdata, q_rdata;

  assign in_item.kind          = in_kind;
  assign in_item.angle_key     = in_angle_key;
  assign in_item.radius_key    = in_radius_key;
  assign in_item.positive_sign = in_positive_sign;
  assign in_item.cone_id       = in_cone_id;

  och_front #(.HEAD_BITS(HEAD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .back_ready (back_ready),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  och_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  och_back #(.HEAD_BITS(HEAD_BITS), .CAPACITY(CAPACITY)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .back_ready     (back_ready),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_cone (out_found_cone)
  );

endmodule
